@@ src/fbct_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbct_pkg
// Shared types, constants and the plane extraction helper for the frustum
// box cull test.
// ----------------------------------------------------------------------------
package fbct_pkg;

    localparam int MATRIX_REGS = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int AXES        = 3;
    localparam int MAX_PLANES  = 6;
    localparam int SUM_W       = 68;
    localparam int W_SHIFT     = 16;

    typedef logic [CFG_DATA_W-1:0] cfg_word_t;
    typedef logic signed [32:0]    comp_t;
    typedef logic signed [64:0]    cprod_t;
    typedef logic [63:0]           hprod_t;
    typedef logic signed [SUM_W-1:0] sum_t;

    // matrix row paired with row 3 for each plane, and whether it is added
    localparam logic [1:0] PLANE_ROW [MAX_PLANES] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
    localparam logic       PLANE_ADD [MAX_PLANES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

    // one plane component from the two register words of one matrix column
    function automatic comp_t plane_comp(input int p, input cfg_word_t r01,
                                         input cfg_word_t r23);
        logic signed [31:0] base;
        logic signed [31:0] m;
        begin
            base = r23[63:32];
            case (PLANE_ROW[p])
                2'd0:    m = r01[31:0];
                2'd1:    m = r01[63:32];
                default: m = r23[31:0];
            endcase
            if (PLANE_ADD[p])
                plane_comp = comp_t'(base) + comp_t'(m);
            else
                plane_comp = comp_t'(base) - comp_t'(m);
        end
    endfunction

endpackage
`default_nettype wire

@@ src/frustum_box_cull_test.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frustum_box_cull_test
// Axis-aligned box against view frustum planes taken from a 4x4 matrix.
// ----------------------------------------------------------------------------
// One box is taken on every cycle in which start is high; busy is always low
// since the pipeline never stalls. The answer comes out after the five
// register stages as a one-cycle done strobe with visible; the receiver cannot
// hold it off. The stages are input capture, the 32x33 plane products, two
// levels of the 68-bit adder tree and the sign test. Matrix registers are
// written through cfg_we/cfg_index/cfg_data and must only change while no box
// is in flight.
module frustum_box_cull_test #(
    parameter int PLANE_COUNT = 6
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    output logic                               done,
    input  wire logic                          cfg_we,
    input  wire logic [fbct_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [fbct_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic signed [31:0]            center_x,
    input  wire logic signed [31:0]            center_y,
    input  wire logic signed [31:0]            center_z,
    input  wire logic [30:0]                   half_x,
    input  wire logic [30:0]                   half_y,
    input  wire logic [30:0]                   half_z,
    output logic                               visible
);

    fbct_pkg::cfg_word_t matrix_reg [fbct_pkg::MATRIX_REGS];

    logic v1_reg, v2_reg, v3_reg, v4_reg, done_reg;
    logic visible_reg, visible_next;

    logic signed [31:0] cen_reg  [fbct_pkg::AXES];
    logic [30:0]        half_reg [fbct_pkg::AXES];

    fbct_pkg::cprod_t cp_reg [PLANE_COUNT][fbct_pkg::AXES];
    fbct_pkg::hprod_t hp_reg [PLANE_COUNT][fbct_pkg::AXES];
    fbct_pkg::sum_t   sa_reg [PLANE_COUNT];
    fbct_pkg::sum_t   sb_reg [PLANE_COUNT];
    fbct_pkg::sum_t   sc_reg [PLANE_COUNT];
    fbct_pkg::sum_t   sw_reg [PLANE_COUNT];
    fbct_pkg::sum_t   u_reg  [PLANE_COUNT];
    fbct_pkg::sum_t   v_reg  [PLANE_COUNT];
    logic [PLANE_COUNT-1:0] neg;

    assign busy    = 1'b0;
    assign done    = done_reg;
    assign visible = visible_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fbct_pkg::MATRIX_REGS; i++)
                matrix_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            matrix_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start && !busy;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            done_reg <= v4_reg;
        end
    end

    // stage 1: capture the box on transfer
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cen_reg[0]  <= center_x;
            cen_reg[1]  <= center_y;
            cen_reg[2]  <= center_z;
            half_reg[0] <= half_x;
            half_reg[1] <= half_y;
            half_reg[2] <= half_z;
        end
    end

    for (genvar p = 0; p < PLANE_COUNT; p++)
    begin : g_plane
        fbct_pkg::comp_t n     [fbct_pkg::AXES];
        logic [32:0]     n_mag [fbct_pkg::AXES];
        fbct_pkg::comp_t w;

        always_comb
        begin
            for (int a = 0; a < fbct_pkg::AXES; a++)
            begin
                n[a]     = fbct_pkg::plane_comp(p, matrix_reg[2*a], matrix_reg[2*a+1]);
                n_mag[a] = n[a][32] ? (~n[a] + 33'd1) : n[a];
            end
            w = fbct_pkg::plane_comp(p, matrix_reg[6], matrix_reg[7]);
        end

        // stage 2: products, stage 3: pair sums, stage 4: halves
        always_ff @(posedge clk)
        begin
            for (int a = 0; a < fbct_pkg::AXES; a++)
            begin
                cp_reg[p][a] <= fbct_pkg::cprod_t'(cen_reg[a]) * fbct_pkg::cprod_t'(n[a]);
                hp_reg[p][a] <= fbct_pkg::hprod_t'(half_reg[a]) * fbct_pkg::hprod_t'(n_mag[a]);
            end
            sa_reg[p] <= fbct_pkg::sum_t'(cp_reg[p][0]) + fbct_pkg::sum_t'(cp_reg[p][1]);
            sb_reg[p] <= fbct_pkg::sum_t'(cp_reg[p][2]) + fbct_pkg::sum_t'(hp_reg[p][0]);
            sc_reg[p] <= fbct_pkg::sum_t'(hp_reg[p][1]) + fbct_pkg::sum_t'(hp_reg[p][2]);
            sw_reg[p] <= fbct_pkg::sum_t'(w) <<< fbct_pkg::W_SHIFT;
            u_reg[p]  <= sa_reg[p] + sb_reg[p];
            v_reg[p]  <= sc_reg[p] + sw_reg[p];
        end

        fbct_pkg::sum_t total;
        assign total  = u_reg[p] + v_reg[p];
        assign neg[p] = total[fbct_pkg::SUM_W-1];
    end

    // stage 5: box is culled if any plane sum is negative
    assign visible_next = ~|neg;

    always_ff @(posedge clk)
    begin
        if (v4_reg)
            visible_reg <= visible_next;
    end

`ifndef SYNTHESIS
    logic matrix_zero;
    always_comb
    begin
        matrix_zero = 1'b1;
        for (int i = 0; i < fbct_pkg::MATRIX_REGS; i++)
            if (matrix_reg[i] != '0)
                matrix_zero = 1'b0;
    end

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##5 done)
        else $error("transfer did not produce a result after five cycles");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 5))
        else $error("result without a transfer five cycles earlier");

    a_zero_matrix: assert property (@(posedge clk) disable iff (!rst_n)
        done && matrix_zero && $past(matrix_zero, 1) && $past(matrix_zero, 2)
        && $past(matrix_zero, 3) && $past(matrix_zero, 4) |-> visible)
        else $error("box culled by an all-zero matrix");
`endif

endmodule
`default_nettype wire
